### hdl/usp_pkg.sv
// Shared types, character codes and the sequencer microprogram for the URI splitter.
`timescale 1ns / 1ps

package usp_pkg;

  // Default depth of the prefix store
  localparam int PrefixDepth = 16;

  // Microprogram counter width
  localparam int UpcW = 5;

  // Part codes
  localparam logic [2:0] PartScheme = 3'd0;
  localparam logic [2:0] PartAuth   = 3'd1;
  localparam logic [2:0] PartPath   = 3'd2;
  localparam logic [2:0] PartQuery  = 3'd3;
  localparam logic [2:0] PartFrag   = 3'd4;

  // Characters the splitter reacts to
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChBrack = 8'h5B;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  // Length of "https"
  localparam logic [2:0] WebLen = 3'd5;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MARK_OVF,
    OP_STORE,
    OP_SCH_INIT,
    OP_RD,
    OP_EMIT_SCH,
    OP_SCH_END,
    OP_REP_INIT,
    OP_RUN_MEM,
    OP_INC,
    OP_CLR_CNT,
    OP_RUN_CH,
    OP_SUMMARY,
    OP_FLUSH
  } op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE_WAIT,
    C_DECIDED,
    C_COLON,
    C_REPLAY,
    C_IDX_END,
    C_RUN_MORE,
    C_NOT_LAST
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [UpcW-1:0] target;
  } uword_t;

  // One result word before the run_last tag is attached
  typedef struct packed {
    logic [7:0] out_char;
    logic [2:0] part;
    logic       is_summary;
    logic       scheme_valid;
    logic       is_web_url;
    logic       prefix_overflow;
  } res_t;

  // Program addresses
  localparam logic [UpcW-1:0] UpcIdle   = 5'd0;
  localparam logic [UpcW-1:0] UpcDisp   = 5'd1;
  localparam logic [UpcW-1:0] UpcColon  = 5'd2;
  localparam logic [UpcW-1:0] UpcClass  = 5'd3;
  localparam logic [UpcW-1:0] UpcStore  = 5'd4;
  localparam logic [UpcW-1:0] UpcSch    = 5'd5;
  localparam logic [UpcW-1:0] UpcSchRd  = 5'd6;
  localparam logic [UpcW-1:0] UpcSchOut = 5'd7;
  localparam logic [UpcW-1:0] UpcSchEnd = 5'd8;
  localparam logic [UpcW-1:0] UpcRep    = 5'd9;
  localparam logic [UpcW-1:0] UpcRepRd  = 5'd10;
  localparam logic [UpcW-1:0] UpcRepRun = 5'd11;
  localparam logic [UpcW-1:0] UpcRepInc = 5'd12;
  localparam logic [UpcW-1:0] UpcRepEnd = 5'd13;
  localparam logic [UpcW-1:0] UpcRun    = 5'd14;
  localparam logic [UpcW-1:0] UpcTail   = 5'd15;
  localparam logic [UpcW-1:0] UpcSumm   = 5'd16;
  localparam logic [UpcW-1:0] UpcFlush  = 5'd17;

  // Control store: next address is target when cond holds, else the following step
  function automatic uword_t ucode(input logic [UpcW-1:0] addr);
    uword_t w;
    w = '{op: OP_ACCEPT, cond: C_IDLE_WAIT, target: UpcIdle};
    case (addr)
      UpcIdle:   w = '{op: OP_ACCEPT,   cond: C_IDLE_WAIT, target: UpcIdle};
      UpcDisp:   w = '{op: OP_NOP,      cond: C_DECIDED,   target: UpcRun};
      UpcColon:  w = '{op: OP_NOP,      cond: C_COLON,     target: UpcSch};
      UpcClass:  w = '{op: OP_MARK_OVF, cond: C_REPLAY,    target: UpcRep};
      UpcStore:  w = '{op: OP_STORE,    cond: C_ALWAYS,    target: UpcFlush};
      UpcSch:    w = '{op: OP_SCH_INIT, cond: C_NEVER,     target: UpcIdle};
      UpcSchRd:  w = '{op: OP_RD,       cond: C_IDX_END,   target: UpcSchEnd};
      UpcSchOut: w = '{op: OP_EMIT_SCH, cond: C_ALWAYS,    target: UpcSchRd};
      UpcSchEnd: w = '{op: OP_SCH_END,  cond: C_ALWAYS,    target: UpcTail};
      UpcRep:    w = '{op: OP_REP_INIT, cond: C_NEVER,     target: UpcIdle};
      UpcRepRd:  w = '{op: OP_RD,       cond: C_IDX_END,   target: UpcRepEnd};
      UpcRepRun: w = '{op: OP_RUN_MEM,  cond: C_RUN_MORE,  target: UpcRepRun};
      UpcRepInc: w = '{op: OP_INC,      cond: C_ALWAYS,    target: UpcRepRd};
      UpcRepEnd: w = '{op: OP_CLR_CNT,  cond: C_NEVER,     target: UpcIdle};
      UpcRun:    w = '{op: OP_RUN_CH,   cond: C_RUN_MORE,  target: UpcRun};
      UpcTail:   w = '{op: OP_NOP,      cond: C_NOT_LAST,  target: UpcFlush};
      UpcSumm:   w = '{op: OP_SUMMARY,  cond: C_NEVER,     target: UpcIdle};
      UpcFlush:  w = '{op: OP_FLUSH,    cond: C_ALWAYS,    target: UpcIdle};
      default:   w = '{op: OP_ACCEPT,   cond: C_IDLE_WAIT, target: UpcIdle};
    endcase
    return w;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_scheme_byte(input logic [7:0] c);
    return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39)) ||
           (c == ChPlus) || (c == ChDot) || (c == ChMinus);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == ChDot) || (c == ChAt) || (c == ChSlash) ||
           (c == ChBrack) || (c == ChQuest) || (c == ChHash);
  endfunction

  // Letters of "https" by position
  function automatic logic [7:0] web_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h70;
      3'd4:    c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/usp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module usp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/uri_component_splitter_unit.sv
// URI component splitter: microcoded sequencer, prefix store and output staging.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o | ch_i, last_i
//   out     | output    | out_valid_o/out_stall_i | out_char_o, part_o, is_summary_o,
//           |           |                         | scheme_valid_o, is_web_url_o,
//           |           |                         | prefix_overflow_o, run_last_o
//
// A byte passes from accept through dispatch and is then either run through the part machine (a
// second run step when it needs another look) or only stored; the final byte adds a summary step.
// A scheme emit takes one prefix store read and one emit step per stored byte; a replay takes a
// read, one or two run steps and an advance per stored byte.
// Each result waits one word in a staging register so run_last can be attached.
// Reset is asynchronous; no clearing pass, only prefix store data below its count is used.
// A stalled output freezes the sequencer at a step that may emit or flush.
`timescale 1ns / 1ps

module uri_component_splitter_unit #(
  parameter int PREFIX_DEPTH = usp_pkg::PrefixDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [2:0] part_o,
  output logic       is_summary_o,
  output logic       scheme_valid_o,
  output logic       is_web_url_o,
  output logic       prefix_overflow_o,
  output logic       run_last_o
);

  localparam int CW = $clog2(PREFIX_DEPTH + 1);
  localparam int AW = $clog2(PREFIX_DEPTH);
  localparam logic [CW-1:0] CntFull = CW'(PREFIX_DEPTH);

  typedef enum logic [2:0] {
    PH_UNDECIDED,
    PH_START,
    PH_SLASH1,
    PH_AUTH,
    PH_PATH,
    PH_QUERY,
    PH_FRAG
  } phase_e;

  logic [usp_pkg::UpcW-1:0] upc_q, upc_d;
  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          valid_q, valid_d;
  logic [2:0]    web_pos_q, web_pos_d;
  logic          web_mis_q, web_mis_d;
  logic          ovf_q, ovf_d;
  logic          scheme_q, scheme_d;
  logic [7:0]    ch_q, ch_d;
  logic          last_q, last_d;
  usp_pkg::res_t pend_q, pend_d;
  logic          pend_valid_q, pend_valid_d;
  usp_pkg::res_t out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          out_last_q, out_last_d;

  usp_pkg::uword_t uw;
  logic            accept;
  logic            out_free;
  logic            emit_ok;
  logic            emit_req;
  usp_pkg::res_t   emit_res;
  logic            hold;
  logic            take;
  logic            is_run;
  logic [7:0]      run_c;
  logic            run_fin;
  phase_e          run_phase;
  logic            run_emit;
  logic [7:0]      run_char;
  logic [2:0]      run_part;
  logic            run_done;
  logic            summ_valid;
  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_rdata;

  // Prefix store
  usp_ram #(
    .WIDTH (8),
    .DEPTH (PREFIX_DEPTH)
  ) u_prefix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ch_q),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Control word fetch and input handshake
  assign uw         = usp_pkg::ucode(upc_q);
  assign in_stall_o = (uw.op != usp_pkg::OP_ACCEPT);
  assign accept     = in_valid_i && (uw.op == usp_pkg::OP_ACCEPT);

  // Part machine: one sub-step per cycle unless the output stalls, done low when the byte needs another look
  assign is_run  = (uw.op == usp_pkg::OP_RUN_MEM) || (uw.op == usp_pkg::OP_RUN_CH);
  assign run_c   = (uw.op == usp_pkg::OP_RUN_MEM) ? ram_rdata : ch_q;
  assign run_fin = (uw.op == usp_pkg::OP_RUN_CH) && last_q;

  always_comb begin
    run_phase = phase_q;
    run_emit  = 1'b0;
    run_char  = run_c;
    run_part  = usp_pkg::PartPath;
    run_done  = 1'b1;
    case (phase_q)
      PH_START: begin
        if ((run_c == usp_pkg::ChSlash) && !run_fin) begin
          run_phase = PH_SLASH1;
        end else begin
          run_phase = PH_PATH;
          run_done  = 1'b0;
        end
      end
      PH_SLASH1: begin
        if (run_c == usp_pkg::ChSlash) begin
          run_phase = PH_AUTH;
        end else begin
          // lone slash is path content, then the byte itself is looked at again in the path phase
          run_emit  = 1'b1;
          run_char  = usp_pkg::ChSlash;
          run_phase = PH_PATH;
          run_done  = 1'b0;
        end
      end
      PH_AUTH: begin
        if (run_c != usp_pkg::ChSlash) begin
          run_emit = 1'b1;
          run_part = usp_pkg::PartAuth;
        end else begin
          run_phase = PH_PATH;
          run_done  = 1'b0;
        end
      end
      PH_PATH: begin
        if (run_c == usp_pkg::ChQuest) begin
          run_phase = PH_QUERY;
        end else begin
          run_emit = 1'b1;
        end
      end
      PH_QUERY: begin
        if (run_c == usp_pkg::ChHash) begin
          run_phase = PH_FRAG;
        end else begin
          run_emit = 1'b1;
          run_part = usp_pkg::PartQuery;
        end
      end
      PH_FRAG: begin
        run_emit = 1'b1;
        run_part = usp_pkg::PartFrag;
      end
      default: begin
        run_done = 1'b1;
      end
    endcase
  end

  // Result source select
  assign summ_valid = scheme_q && valid_q;

  always_comb begin
    emit_res = '0;
    emit_req = 1'b0;
    case (uw.op)
      usp_pkg::OP_RUN_MEM, usp_pkg::OP_RUN_CH: begin
        emit_req          = run_emit;
        emit_res.out_char = run_char;
        emit_res.part     = run_part;
      end
      usp_pkg::OP_EMIT_SCH: begin
        emit_req          = 1'b1;
        emit_res.out_char = ram_rdata;
        emit_res.part     = usp_pkg::PartScheme;
      end
      usp_pkg::OP_SUMMARY: begin
        emit_req                 = 1'b1;
        emit_res.is_summary      = 1'b1;
        emit_res.scheme_valid    = summ_valid;
        emit_res.is_web_url      = summ_valid && !web_mis_q &&
                                   ((web_pos_q == 3'd4) || (web_pos_q == usp_pkg::WebLen));
        emit_res.prefix_overflow = ovf_q;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // Stall: a step that may emit waits until the staging word can move on
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_ok  = !pend_valid_q || out_free;
  assign hold = ((is_run || (uw.op == usp_pkg::OP_EMIT_SCH) ||
                  (uw.op == usp_pkg::OP_SUMMARY)) && !emit_ok) ||
                ((uw.op == usp_pkg::OP_FLUSH) && pend_valid_q && !out_free);

  // Jump condition
  always_comb begin
    case (uw.cond)
      usp_pkg::C_NEVER:     take = 1'b0;
      usp_pkg::C_ALWAYS:    take = 1'b1;
      usp_pkg::C_IDLE_WAIT: take = !accept;
      usp_pkg::C_DECIDED:   take = (phase_q != PH_UNDECIDED);
      usp_pkg::C_COLON:     take = (ch_q == usp_pkg::ChColon);
      usp_pkg::C_REPLAY:    take = usp_pkg::is_delim(ch_q) || (cnt_q == CntFull) || last_q;
      usp_pkg::C_IDX_END:   take = (idx_q == cnt_q);
      usp_pkg::C_RUN_MORE:  take = !run_done;
      usp_pkg::C_NOT_LAST:  take = !last_q;
      default:              take = 1'b0;
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    upc_d        = upc_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    web_pos_d    = web_pos_q;
    web_mis_d    = web_mis_q;
    ovf_d        = ovf_q;
    scheme_d     = scheme_q;
    ch_d         = ch_q;
    last_d       = last_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (!hold) begin
      upc_d = take ? uw.target : upc_q + 1'b1;
      case (uw.op)
        usp_pkg::OP_ACCEPT: begin
          if (accept) begin
            ch_d   = ch_i;
            last_d = last_i;
          end
        end
        usp_pkg::OP_MARK_OVF: begin
          if ((cnt_q == CntFull) && !usp_pkg::is_delim(ch_q)) begin
            ovf_d = 1'b1;
          end
        end
        usp_pkg::OP_STORE: begin
          ram_we = 1'b1;
          if (cnt_q == '0) begin
            valid_d = usp_pkg::is_alpha(ch_q);
          end else if (!usp_pkg::is_scheme_byte(ch_q)) begin
            valid_d = 1'b0;
          end
          if ((web_pos_q < usp_pkg::WebLen) && (usp_pkg::web_char(web_pos_q) == ch_q)) begin
            web_pos_d = web_pos_q + 1'b1;
          end else begin
            web_mis_d = 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
        end
        usp_pkg::OP_SCH_INIT: begin
          idx_d    = '0;
          scheme_d = 1'b1;
          phase_d  = PH_START;
          if (cnt_q == '0) begin
            valid_d = 1'b0;
          end
        end
        usp_pkg::OP_RD: begin
          ram_re = 1'b1;
        end
        usp_pkg::OP_EMIT_SCH, usp_pkg::OP_INC: begin
          idx_d = idx_q + 1'b1;
        end
        usp_pkg::OP_SCH_END, usp_pkg::OP_CLR_CNT: begin
          cnt_d = '0;
        end
        usp_pkg::OP_REP_INIT: begin
          idx_d    = '0;
          scheme_d = 1'b0;
          phase_d  = PH_START;
        end
        usp_pkg::OP_RUN_MEM, usp_pkg::OP_RUN_CH: begin
          phase_d = run_phase;
        end
        usp_pkg::OP_SUMMARY: begin
          // every part starts empty for the next URI
          phase_d   = PH_UNDECIDED;
          cnt_d     = '0;
          valid_d   = 1'b0;
          web_pos_d = '0;
          web_mis_d = 1'b0;
          ovf_d     = 1'b0;
          scheme_d  = 1'b0;
        end
        default: begin
          upc_d = take ? uw.target : upc_q + 1'b1;
        end
      endcase

      // Staging: a new word pushes the held one out, not yet last
      if (emit_req) begin
        if (pend_valid_q) begin
          out_d       = pend_q;
          out_last_d  = 1'b0;
          out_valid_d = 1'b1;
        end
        pend_d       = emit_res;
        pend_valid_d = 1'b1;
      end

      // End of item: the held word is the last one
      if ((uw.op == usp_pkg::OP_FLUSH) && pend_valid_q) begin
        out_d        = pend_q;
        out_last_d   = 1'b1;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= usp_pkg::UpcIdle;
      phase_q      <= PH_UNDECIDED;
      cnt_q        <= '0;
      idx_q        <= '0;
      valid_q      <= 1'b0;
      web_pos_q    <= '0;
      web_mis_q    <= 1'b0;
      ovf_q        <= 1'b0;
      scheme_q     <= 1'b0;
      ch_q         <= '0;
      last_q       <= 1'b0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      out_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      upc_q        <= upc_d;
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      valid_q      <= valid_d;
      web_pos_q    <= web_pos_d;
      web_mis_q    <= web_mis_d;
      ovf_q        <= ovf_d;
      scheme_q     <= scheme_d;
      ch_q         <= ch_d;
      last_q       <= last_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      out_q        <= out_d;
      out_last_q   <= out_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output port
  assign out_valid_o       = out_valid_q;
  assign out_char_o        = out_q.out_char;
  assign part_o            = out_q.part;
  assign is_summary_o      = out_q.is_summary;
  assign scheme_valid_o    = out_q.scheme_valid;
  assign is_web_url_o      = out_q.is_web_url;
  assign prefix_overflow_o = out_q.prefix_overflow;
  assign run_last_o        = out_last_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input taken again before the sequencer left idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("prefix count beyond store depth");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == usp_pkg::UpcIdle) |-> !pend_valid_q)
    else $error("staged result left over at idle");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_summary_o) |-> (run_last_o && (out_char_o == 8'h00) &&
                                       (part_o == usp_pkg::PartScheme)))
    else $error("summary word malformed");

  a_summary_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((uw.op == usp_pkg::OP_SUMMARY) && !hold) |=>
      ((phase_q == PH_UNDECIDED) && (cnt_q == '0) && !ovf_q))
    else $error("state not cleared after summary");

endmodule
